// ===== hdl/ips_pkg.sv =====
// Shared types and constants for the IPv4 payload injection scanner.
package ips_pkg;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 16;
  localparam int TOTAL_W = 32;
  localparam int NUM_CNT = 6;
  localparam int OUT_W   = 216;

  localparam logic [LEN_W-1:0] SCAN_LIMIT_RESET = 16'd1500;
  localparam logic [LEN_W-1:0] POS_MAX          = 16'hFFFF;

  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [5:0] MIN_HDR    = 6'd20;
  localparam logic [6:0] UDP_HDR    = 7'd8;

  // Header byte offsets.
  localparam logic [LEN_W-1:0] OFS_TOTLEN_HI = 16'd2;
  localparam logic [LEN_W-1:0] OFS_TOTLEN_LO = 16'd3;
  localparam logic [LEN_W-1:0] OFS_PROTO     = 16'd9;
  localparam logic [LEN_W-1:0] OFS_UDPLEN_HI = 16'd4;
  localparam logic [LEN_W-1:0] OFS_UDPLEN_LO = 16'd5;
  localparam logic [LEN_W-1:0] OFS_TCP_DOFF  = 16'd12;

  // Pattern characters; CASE_BIT folds upper case letters onto lower case.
  localparam logic [7:0] CASE_BIT  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_J      = 8'h6A;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_O      = 8'h6F;

  // Tail room that a match must leave inside the window.
  localparam logic [LEN_W:0] JNDI_TAIL  = 17'd8;
  localparam logic [LEN_W:0] UNION_TAIL = 17'd2;
  localparam logic [LEN_W-1:0] JNDI_LEAD  = 16'd2;
  localparam logic [LEN_W-1:0] UNION_LEAD = 16'd4;

  // Counter bank slots.
  localparam int CNT_PACKETS = 0;
  localparam int CNT_BYTES   = 1;
  localparam int CNT_MATCHES = 2;
  localparam int CNT_BLOCKED = 3;
  localparam int CNT_EXPLOIT = 4;
  localparam int CNT_CVE     = 5;

  typedef enum logic [1:0] {
    RULE_NONE  = 2'd0,
    RULE_JNDI  = 2'd1,
    RULE_UNION = 2'd2
  } rule_t;

  // Payload window as seen by the scanner.
  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] length;
    logic [LEN_W-1:0] start;
  } win_t;

  typedef logic [NUM_CNT-1:0][TOTAL_W-1:0] totals_t;

endpackage

// ===== hdl/ipv4_payload_injection_scan.sv =====
// Top level of the IPv4 payload injection scanner with its output stage.
//
// Packet bytes enter on the s_ channel, one byte per transfer, starting at the
// IPv4 header; s_tlast marks the final byte of a packet. The block parses the
// IPv4 header and the TCP or UDP header, derives the payload window, clamps it
// to scan_limit, and searches the window for a "${j" lookup and for the word
// "union". On the final byte of each packet one result transfer leaves on the
// m_ channel with the verdict, the rule hit, the scanned length and six
// saturating statistics counters. Other bytes produce no output.
// Throughput is one byte per cycle while s_tready is high: every byte is folded into the
// parser and matcher state in the cycle it is accepted. The result is registered: it enters
// the output register, or the skid register while the output register is still held.
// When the receiver stalls, a waiting result sits in the output register and
// bytes keep flowing; a second result lands in a skid register, and only while
// that skid register is occupied does s_tready drop.
// scan_limit is written through cfg_wr_en/cfg_wr_data and resets to 1500.
// A synchronous reset clears the packet state, the counters and the valid flags
// of both output registers.
module ipv4_payload_injection_scan #(
  parameter int COUNTER_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,  // [7:0] packet_byte
  input  logic                      s_tlast,  // end_of_packet
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // m_tdata, lowest bit first: verdict[0], rule_hit[2:1], scanned_length[18:3],
  // total_packets[50:19], scanned_bytes[82:51], total_matches[114:83],
  // dropped_packets[146:115], exploit_hits[178:147], cve_hits[210:179], zero fill.
  output logic [ips_pkg::OUT_W-1:0] m_tdata,
  input  logic                      cfg_wr_en,
  input  logic [15:0]               cfg_wr_data
);
  import ips_pkg::*;

  logic [15:0]      scan_limit;
  logic             accept, finish, take;
  logic [15:0]      pos;
  win_t             win;
  logic [15:0]      scanned;
  logic             jndi_any, union_any;
  rule_t            rule;
  totals_t          totals;
  logic [OUT_W-1:0] res_data;
  logic             skid_valid;
  logic [OUT_W-1:0] skid_data;
  logic             load_out, load_skid;

  assign accept = s_tvalid && s_tready;
  assign finish = accept && s_tlast;
  assign take   = m_tvalid && m_tready;

  // The skid register is the only thing that can hold the input back.
  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit <= SCAN_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      scan_limit <= cfg_wr_data;
    end
  end

  ips_hdr u_hdr (
    .clk        (clk),
    .rst        (rst),
    .en         (accept),
    .last       (s_tlast),
    .pkt_byte   (s_tdata),
    .scan_limit (scan_limit),
    .pos        (pos),
    .win        (win),
    .scanned    (scanned)
  );

  ips_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .en        (accept),
    .last      (s_tlast),
    .pkt_byte  (s_tdata),
    .pos       (pos),
    .win       (win),
    .jndi_any  (jndi_any),
    .union_any (union_any)
  );

  // The lookup rule wins when both patterns were seen in one packet.
  always_comb begin
    priority if (jndi_any) begin
      rule = RULE_JNDI;
    end else if (union_any) begin
      rule = RULE_UNION;
    end else begin
      rule = RULE_NONE;
    end
  end

  ips_cnt #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_cnt (
    .clk     (clk),
    .rst     (rst),
    .upd     (finish),
    .rule    (rule),
    .scanned (scanned),
    .totals  (totals)
  );

  assign res_data = {5'd0,
                     totals[CNT_CVE], totals[CNT_EXPLOIT], totals[CNT_BLOCKED],
                     totals[CNT_MATCHES], totals[CNT_BYTES], totals[CNT_PACKETS],
                     scanned, rule, (rule != RULE_NONE)};

  // A new result goes to the output register when it is free or draining,
  // and into the skid register otherwise. A finishing transfer never meets a
  // full skid register, since s_tready is low then.
  assign load_out  = finish && (!m_tvalid || take);
  assign load_skid = finish && m_tvalid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid && take) begin
      skid_valid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (load_skid) begin
      skid_valid <= 1'b1;
    end else if (take) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && take) begin
      m_tdata <= skid_data;
    end else if (load_out) begin
      m_tdata <= res_data;
    end
    if (load_skid) begin
      skid_data <= res_data;
    end
  end

  // The skid register only fills behind an occupied output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid) else $error("skid register holds data ahead of output");

  // After every final byte, m_tvalid is high in the following cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    finish |=> m_tvalid) else $error("final byte produced no result");

  // The verdict is drop exactly when a rule matched.
  a_verdict_rule: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] != RULE_NONE)))
    else $error("verdict disagrees with rule hit");

endmodule

// ===== hdl/ips_hdr.sv =====
// Header parser: byte position, IPv4 and transport fields, payload window.
module ips_hdr (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                last,
  input  logic [7:0]          pkt_byte,
  input  logic [15:0]         scan_limit,
  output logic [15:0]         pos,
  output ips_pkg::win_t       win,
  output logic [15:0]         scanned
);
  import ips_pkg::*;

  logic [5:0]  ihl, ihl_next, ihl_eff;
  logic [7:0]  proto, proto_next;
  logic [15:0] tot_len, tot_len_next;
  logic [5:0]  thl, thl_next, thl_new;
  logic [15:0] udp_len, udp_len_next, udp_full;
  logic [15:0] win_len, win_len_next;
  logic        win_valid, win_valid_next;
  logic [15:0] pos_next;
  logic        hdr_ok;
  logic [6:0]  tcp_hdr;
  logic [15:0] tcp_pay;
  logic        open_req;
  logic [15:0] open_len;
  logic [6:0]  start;

  always_comb begin
    ihl_eff      = (pos == '0) ? {pkt_byte[3:0], 2'b00} : ihl;
    ihl_next     = ihl_eff;
    proto_next   = (pos == OFS_PROTO) ? pkt_byte : proto;
    tot_len_next = tot_len;
    if (pos == OFS_TOTLEN_HI) tot_len_next = {pkt_byte, tot_len[7:0]};
    if (pos == OFS_TOTLEN_LO) tot_len_next = {tot_len[15:8], pkt_byte};

    hdr_ok   = (pos != '0) && (ihl_eff >= MIN_HDR);
    thl_new  = {pkt_byte[7:4], 2'b00};
    tcp_hdr  = {1'b0, ihl_eff} + {1'b0, thl_new};
    tcp_pay  = tot_len - {9'd0, tcp_hdr};
    udp_full = {udp_len[15:8], pkt_byte};

    thl_next     = thl;
    udp_len_next = udp_len;
    open_req     = 1'b0;
    open_len     = '0;
    if (hdr_ok && pos == {10'd0, ihl_eff} + OFS_TCP_DOFF) begin
      thl_next = thl_new;
      if (proto == PROTO_TCP && thl_new >= MIN_HDR && tot_len >= {9'd0, tcp_hdr}) begin
        open_req = 1'b1;
        open_len = tcp_pay;
      end
    end
    if (hdr_ok && pos == {10'd0, ihl_eff} + OFS_UDPLEN_HI) begin
      udp_len_next = {pkt_byte, udp_len[7:0]};
    end
    if (hdr_ok && pos == {10'd0, ihl_eff} + OFS_UDPLEN_LO) begin
      udp_len_next = udp_full;
      if (proto == PROTO_UDP && udp_full >= {9'd0, UDP_HDR}) begin
        open_req = 1'b1;
        open_len = udp_full - {9'd0, UDP_HDR};
      end
    end

    // A zero payload leaves the window closed.
    win_len_next   = win_len;
    win_valid_next = win_valid;
    if (open_req && open_len != '0) begin
      win_len_next   = (open_len > scan_limit) ? scan_limit : open_len;
      win_valid_next = 1'b1;
    end

    pos_next = (pos == POS_MAX) ? pos : pos + 16'd1;
    scanned  = win_valid_next ? win_len_next : '0;

    start = (proto == PROTO_TCP) ? ({1'b0, ihl} + {1'b0, thl}) : ({1'b0, ihl} + UDP_HDR);
    win   = '{valid: win_valid, length: win_len, start: {9'd0, start}};
  end

  always_ff @(posedge clk) begin
    if (rst || (en && last)) begin
      pos       <= '0;
      ihl       <= '0;
      proto     <= '0;
      tot_len   <= '0;
      thl       <= '0;
      udp_len   <= '0;
      win_len   <= '0;
      win_valid <= 1'b0;
    end else if (en) begin
      pos       <= pos_next;
      ihl       <= ihl_next;
      proto     <= proto_next;
      tot_len   <= tot_len_next;
      thl       <= thl_next;
      udp_len   <= udp_len_next;
      win_len   <= win_len_next;
      win_valid <= win_valid_next;
    end
  end

endmodule

// ===== hdl/ips_scan.sv =====
// Payload matcher: four byte history and the two rule flags.
module ips_scan (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          last,
  input  logic [7:0]    pkt_byte,
  input  logic [15:0]   pos,
  input  ips_pkg::win_t win,
  output logic          jndi_any,
  output logic          union_any
);
  import ips_pkg::*;

  logic [31:0] recent;
  logic        jndi_found, union_found;
  logic [15:0] k;
  logic        in_win, jndi_hit, union_hit;
  logic [7:0]  r1, r2, r3, r4, bl;

  always_comb begin
    r1 = recent[7:0];
    r2 = recent[15:8];
    r3 = recent[23:16];
    r4 = recent[31:24];
    bl = pkt_byte | CASE_BIT;
    k  = pos - win.start;
    in_win = win.valid && (pos != POS_MAX) && (pos >= win.start) && (k < win.length);
    jndi_hit = in_win && (k >= JNDI_LEAD) && (({1'b0, k} + JNDI_TAIL) < {1'b0, win.length}) &&
               (r2 == CH_DOLLAR) && (r1 == CH_LBRACE) && (bl == CH_J);
    union_hit = in_win && (k >= UNION_LEAD) &&
                (({1'b0, k} + UNION_TAIL) < {1'b0, win.length}) &&
                ((r4 | CASE_BIT) == CH_U) && ((r3 | CASE_BIT) == CH_N) &&
                ((r2 | CASE_BIT) == CH_I) && ((r1 | CASE_BIT) == CH_O) && (bl == CH_N);
    jndi_any  = jndi_found || jndi_hit;
    union_any = union_found || union_hit;
  end

  always_ff @(posedge clk) begin
    if (rst || (en && last)) begin
      recent      <= '0;
      jndi_found  <= 1'b0;
      union_found <= 1'b0;
    end else if (en) begin
      recent      <= {recent[23:0], pkt_byte};
      jndi_found  <= jndi_any;
      union_found <= union_any;
    end
  end

  // A flag is only ever raised inside an open window, and both clear together.
  a_jndi_in_window: assert property (@(posedge clk) disable iff (rst)
    jndi_found |-> win.valid) else $error("jndi flag set without a window");
  a_union_in_window: assert property (@(posedge clk) disable iff (rst)
    union_found |-> win.valid) else $error("union flag set without a window");

endmodule

// ===== hdl/ips_cnt.sv =====
// Saturating statistics counters, updated once per finished packet.
module ips_cnt #(
  parameter int COUNTER_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             upd,
  input  ips_pkg::rule_t   rule,
  input  logic [15:0]      scanned,
  output ips_pkg::totals_t totals
);
  import ips_pkg::*;

  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  logic [COUNTER_BITS-1:0] bank      [NUM_CNT];
  logic [COUNTER_BITS-1:0] bank_next [NUM_CNT];
  logic [15:0]             amount    [NUM_CNT];
  logic [COUNTER_BITS:0]   sum       [NUM_CNT];
  logic [COUNTER_BITS+31:0] wide     [NUM_CNT];
  logic                    hit;

  always_comb begin
    hit = (rule != RULE_NONE);
    amount[CNT_PACKETS] = 16'd1;
    amount[CNT_BYTES]   = scanned;
    amount[CNT_MATCHES] = {15'd0, hit};
    amount[CNT_BLOCKED] = {15'd0, hit};
    amount[CNT_EXPLOIT] = {15'd0, rule == RULE_UNION};
    amount[CNT_CVE]     = {15'd0, rule == RULE_JNDI};
    for (int i = 0; i < NUM_CNT; i++) begin
      sum[i] = {1'b0, bank[i]} + {{(COUNTER_BITS - 15){1'b0}}, amount[i]};
      bank_next[i] = (sum[i] >= {1'b0, CNT_MAX}) ? CNT_MAX : sum[i][COUNTER_BITS-1:0];
      wide[i] = {32'd0, bank_next[i]};
      totals[i] = wide[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CNT; i++) bank[i] <= '0;
    end else if (upd) begin
      for (int i = 0; i < NUM_CNT; i++) bank[i] <= bank_next[i];
    end
  end

  // Every flagged packet is both a match and a block, so the two stay equal.
  a_match_eq_block: assert property (@(posedge clk) disable iff (rst)
    bank[CNT_MATCHES] == bank[CNT_BLOCKED]) else $error("match and block counts diverged");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the IPv4 payload injection scanner: random packets, scored per packet.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ips_pkg::*;

  // The counter width is left at its default so that the counters are full 32-bit words.
  localparam int CTR_BITS = 32;
  // The longest stretch in which no transfer can happen in a correct run is a short pause
  // between phases plus a few random stalls. Anything near this bound means the block hung.
  localparam int QUIET_LIMIT = 1000;

  // One byte on the slave side together with its end-of-packet mark.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } octet_t;

  typedef logic [7:0] octets_t[$];

  // Everything that one packet verdict carries on the master side.
  typedef struct packed {
    logic             verdict;
    rule_t            rule;
    logic [LEN_W-1:0] scanned;
    totals_t          totals;
  } verdict_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = 8'h00;  // [7:0] packet_byte
  logic             s_tlast = 1'b0;   // end_of_packet
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;          // verdict, rule_hit, scanned_length, six totals, zero fill
  logic             cfg_wr_en = 1'b0;
  logic [15:0]      cfg_wr_data = 16'h0000;

  ipv4_payload_injection_scan #(
    .COUNTER_BITS(CTR_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Bytes waiting to be offered on the slave side, and verdicts the scanner still owes us.
  octet_t   byte_backlog[$];
  verdict_t verdicts_due[$];
  octet_t   next_octet;

  // When jitter is set, both sides idle or stall in roughly one cycle of five.
  bit       jitter = 1'b1;
  int       mismatches = 0;
  int       quiet_cycles = 0;

  string total_names [NUM_CNT] = '{"total_packets", "scanned_bytes", "total_matches",
                                   "dropped_packets", "exploit_hits", "cve_hits"};

  // ------------------------------------------------------------------------------------------
  // Scanner model. It mirrors the parser and the matcher byte by byte and produces the verdict
  // that the block must send when a packet ends.
  // ------------------------------------------------------------------------------------------
  logic [15:0]     limit_cfg;
  logic [15:0]     pos;
  logic [15:0]     ip_len;
  logic [15:0]     udp_len;
  logic [15:0]     win_len;
  logic [5:0]      hdr_len;
  logic [5:0]      l4_len;
  logic [7:0]      proto;
  logic            win_open;
  logic            saw_jndi;
  logic            saw_union;
  logic [31:0]     history;
  longint unsigned tally [NUM_CNT];

  function automatic void forget_packet();
    pos       = '0;
    hdr_len   = '0;
    proto     = '0;
    ip_len    = '0;
    l4_len    = '0;
    udp_len   = '0;
    win_len   = '0;
    win_open  = 1'b0;
    history   = '0;
    saw_jndi  = 1'b0;
    saw_union = 1'b0;
  endfunction

  // A zero payload opens no window; otherwise the window is the payload clamped to the limit.
  function automatic void open_window(input int unsigned amount);
    if (amount != 0) begin
      win_len  = (amount > limit_cfg) ? limit_cfg : 16'(amount);
      win_open = 1'b1;
    end
  endfunction

  // Counters stick at their top value instead of wrapping.
  function automatic void bump(input int idx, input longint unsigned amount);
    longint unsigned top;
    top = (64'd1 << CTR_BITS) - 1;
    if (amount >= top - tally[idx]) tally[idx] = top;
    else tally[idx] = tally[idx] + amount;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b, input logic last);
    int unsigned p, hl, start, k, hdr;
    logic [7:0]  r1, r2, r3, r4;
    verdict_t    v;
    p  = pos;
    hl = hdr_len;

    // Header capture. The IP header length only counts once it reaches the legal minimum.
    if (p == 0) begin
      hdr_len = {b[3:0], 2'b00};
      hl      = hdr_len;
    end
    if (p == OFS_TOTLEN_HI) ip_len[15:8] = b;
    if (p == OFS_TOTLEN_LO) ip_len[7:0] = b;
    if (p == OFS_PROTO) proto = b;

    if (p != 0 && hl >= MIN_HDR) begin
      if (p == hl + OFS_TCP_DOFF) begin
        l4_len = {b[7:4], 2'b00};
        if (proto == PROTO_TCP && l4_len >= MIN_HDR) begin
          hdr = hl + l4_len;
          if (ip_len >= hdr) open_window(32'(ip_len) - hdr);
        end
      end
      if (p == hl + OFS_UDPLEN_HI) udp_len[15:8] = b;
      if (p == hl + OFS_UDPLEN_LO) begin
        udp_len[7:0] = b;
        if (proto == PROTO_UDP && udp_len >= UDP_HDR) open_window(32'(udp_len) - UDP_HDR);
      end
    end

    // Payload scan. A position stuck at its ceiling is never inspected.
    if (win_open && p < POS_MAX) begin
      start = (proto == PROTO_TCP) ? hl + l4_len : hl + UDP_HDR;
      if (p >= start && p - start < win_len) begin
        k = p - start;
        {r4, r3, r2, r1} = history;
        if (k >= JNDI_LEAD && k + JNDI_TAIL < win_len &&
            r2 == CH_DOLLAR && r1 == CH_LBRACE && (b | CASE_BIT) == CH_J)
          saw_jndi = 1'b1;
        if (k >= UNION_LEAD && k + UNION_TAIL < win_len &&
            (r4 | CASE_BIT) == CH_U && (r3 | CASE_BIT) == CH_N &&
            (r2 | CASE_BIT) == CH_I && (r1 | CASE_BIT) == CH_O && (b | CASE_BIT) == CH_N)
          saw_union = 1'b1;
      end
    end

    history = {history[23:0], b};
    if (pos != POS_MAX) pos = pos + 16'd1;

    if (last) begin
      // The lookup rule outranks the keyword rule when both fired in one packet.
      v.rule    = saw_jndi ? RULE_JNDI : (saw_union ? RULE_UNION : RULE_NONE);
      v.verdict = (v.rule != RULE_NONE);
      v.scanned = win_open ? win_len : '0;
      bump(CNT_PACKETS, 1);
      bump(CNT_BYTES, v.scanned);
      if (v.rule != RULE_NONE) begin
        bump(CNT_MATCHES, 1);
        bump((v.rule == RULE_JNDI) ? CNT_CVE : CNT_EXPLOIT, 1);
        bump(CNT_BLOCKED, 1);
      end
      for (int i = 0; i < NUM_CNT; i++) v.totals[i] = tally[i][31:0];
      verdicts_due.push_back(v);
      forget_packet();
    end
  endfunction

  // ------------------------------------------------------------------------------------------
  // Slave-side driver. A byte is scored by the model at the edge where its transfer completes;
  // the data stays put for as long as the scanner holds s_tready low.
  // ------------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) absorb_byte(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (byte_backlog.size() != 0 && !(jitter && $urandom_range(99) < 19)) begin
          next_octet = byte_backlog.pop_front();
          s_tvalid  <= 1'b1;
          s_tdata   <= next_octet.data;
          s_tlast   <= next_octet.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------------------------
  // Master-side monitor. Each result transfer is split into its fields and compared with the
  // oldest verdict the model produced.
  // ------------------------------------------------------------------------------------------
  function automatic void report_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_verdict(input logic [OUT_W-1:0] d);
    verdict_t want;
    if (verdicts_due.size() == 0) begin
      $error("result transfer arrived with no packet outstanding");
      mismatches++;
    end else begin
      want = verdicts_due.pop_front();
      report_field("verdict", want.verdict, d[0]);
      report_field("rule_hit", want.rule, d[2:1]);
      report_field("scanned_length", want.scanned, d[18:3]);
      for (int i = 0; i < NUM_CNT; i++)
        report_field(total_names[i], want.totals[i], d[19 + 32 * i +: 32]);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_verdict(m_tdata);
      m_tready <= !(jitter && $urandom_range(99) < 19);
    end
  end

  // The watchdog ends a run that has stopped moving: no transfer on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL ipv4_payload_injection_scan");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------------------------
  // Packet construction.
  // ------------------------------------------------------------------------------------------

  // Lays out an IPv4 header, a TCP or UDP header and the payload. Header lengths below the
  // legal minimum are written into the header as given, but twenty bytes are still sent.
  function automatic octets_t assemble_packet(input int unsigned ihl_w, input logic [7:0] proto_id,
                                              input int unsigned l4_w, input logic [15:0] tot,
                                              input logic [15:0] ulen, input octets_t body);
    octets_t     pkt;
    int unsigned hlen, l4bytes;
    hlen = (ihl_w >= 5) ? ihl_w * 4 : 20;
    repeat (hlen) pkt.push_back(8'($urandom));
    pkt[0] = {4'h4, 4'(ihl_w)};
    pkt[OFS_TOTLEN_HI] = tot[15:8];
    pkt[OFS_TOTLEN_LO] = tot[7:0];
    pkt[OFS_PROTO]     = proto_id;
    if (proto_id == PROTO_TCP) begin
      l4bytes = (l4_w >= 5) ? l4_w * 4 : 20;
      repeat (l4bytes) pkt.push_back(8'($urandom));
      pkt[hlen + OFS_TCP_DOFF] = {4'(l4_w), 4'($urandom)};
    end else begin
      repeat (UDP_HDR) pkt.push_back(8'($urandom));
      pkt[hlen + OFS_UDPLEN_HI] = ulen[15:8];
      pkt[hlen + OFS_UDPLEN_LO] = ulen[7:0];
    end
    foreach (body[i]) pkt.push_back(body[i]);
    return pkt;
  endfunction

  // Writes a pattern into the payload at a given offset, with letters in random case. Parts
  // that fall outside the payload are dropped.
  function automatic octets_t plant(input octets_t body, input string word, input int at);
    logic [7:0] c;
    for (int i = 0; i < word.len(); i++) begin
      c = word[i];
      if (c >= "a" && c <= "z" && $urandom_range(1)) c = c ^ CASE_BIT;
      if (at + i >= 0 && at + i < body.size()) body[at + i] = c;
    end
    return body;
  endfunction

  // Picks where a pattern starts so that its final byte lands on the earliest offset the rule
  // accepts, the last one it accepts, the first one past the tail room, or somewhere at random.
  function automatic int pick_spot(input int w, input int plen, input int tail, input int pl);
    int k_end;
    case ($urandom_range(4))
      0:       k_end = plen - 1;
      1:       k_end = w - tail - 1;
      2:       k_end = w - tail;
      default: k_end = $urandom_range(pl + 1);
    endcase
    return k_end - (plen - 1);
  endfunction

  function automatic octets_t random_packet(input int unsigned limit, input int unsigned max_pl);
    octets_t     body, pkt;
    int unsigned ihl_w, l4_w, pl, w, hlen, l4bytes, tot, ulen, roll, cut;
    logic [7:0]  proto_id;
    string       lure;
    lure = "${jJuUnNiIoO";

    roll  = $urandom_range(99);
    ihl_w = (roll < 8) ? $urandom_range(4) : ((roll < 25) ? $urandom_range(15, 6) : 5);
    roll  = $urandom_range(99);
    proto_id = (roll < 55) ? PROTO_TCP : ((roll < 90) ? PROTO_UDP : 8'($urandom));
    roll  = $urandom_range(99);
    l4_w  = (roll < 8) ? $urandom_range(4) : ((roll < 25) ? $urandom_range(15, 6) : 5);

    // Payload bytes lean toward the pattern characters so that near misses are common.
    pl = $urandom_range(max_pl);
    repeat (pl) begin
      if ($urandom_range(1)) body.push_back(lure[$urandom_range(lure.len() - 1)]);
      else body.push_back(8'($urandom));
    end
    w = (pl < limit) ? pl : limit;
    roll = $urandom_range(99);
    if (roll < 50)
      body = plant(body, "${j", pick_spot(w, 3, JNDI_TAIL, pl));
    if (roll >= 35 && roll < 85)
      body = plant(body, "union", pick_spot(w, 5, UNION_TAIL, pl));

    // Mostly consistent lengths; now and then a random or an underflowing one.
    hlen    = (ihl_w >= 5) ? ihl_w * 4 : 20;
    l4bytes = (proto_id == PROTO_TCP) ? ((l4_w >= 5) ? l4_w * 4 : 20) : UDP_HDR;
    tot     = hlen + l4bytes + pl;
    ulen    = UDP_HDR + pl;
    roll = $urandom_range(99);
    if (roll < 6) tot = $urandom_range(65535);
    else if (roll < 12) tot = $urandom_range(hlen + l4bytes);
    roll = $urandom_range(99);
    if (roll < 6) ulen = $urandom_range(9);
    else if (roll < 9) ulen = $urandom_range(65535);

    pkt = assemble_packet(ihl_w, proto_id, l4_w, 16'(tot), 16'(ulen), body);

    // Some packets end early, anywhere down to the first byte; some run past their length.
    roll = $urandom_range(99);
    if (roll < 10) begin
      cut = $urandom_range(pkt.size(), 1);
      pkt = pkt[0:cut-1];
    end else if (roll < 18) begin
      repeat ($urandom_range(8, 1)) pkt.push_back(8'($urandom));
    end
    return pkt;
  endfunction

  function automatic void send_packet(input octets_t pkt);
    octet_t o;
    foreach (pkt[i]) begin
      o.data = pkt[i];
      o.last = (i == pkt.size() - 1);
      byte_backlog.push_back(o);
    end
  endfunction

  // Waits until every byte has gone in and every verdict has come out, then lets the output
  // stage settle so the scanner is truly idle.
  task automatic drain();
    do @(negedge clk);
    while (byte_backlog.size() != 0 || s_tvalid || verdicts_due.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // The register is written only while the scanner is idle; the model follows at the same edge.
  task automatic set_scan_limit(input logic [15:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_cfg = value;
    @(negedge clk);
  endtask

  // ------------------------------------------------------------------------------------------
  // Test sequence.
  // ------------------------------------------------------------------------------------------
  initial begin
    octets_t     pkt;
    octets_t     body;
    int          phase;
    int unsigned bytes_sent;
    logic [15:0] limit;

    forget_packet();
    foreach (tally[i]) tally[i] = 0;
    limit_cfg    = SCAN_LIMIT_RESET;
    bytes_sent   = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed packets under the reset limit. Two one-byte packets carry the largest and the
    // smallest byte and end before any header is complete.
    send_packet('{8'hFF});
    send_packet('{8'h00});
    // A UDP window of eleven bytes with the lookup on the last offset it may end at.
    body = '{CH_DOLLAR, CH_LBRACE, CH_J ^ CASE_BIT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
             8'h00, 8'h00, 8'h00};
    send_packet(assemble_packet(5, PROTO_UDP, 5, 16'd39, 16'd19, body));
    // A TCP window of seven bytes with the keyword, in mixed case, on its last legal offset.
    body = '{CH_U ^ CASE_BIT, CH_N, CH_I ^ CASE_BIT, CH_O, CH_N ^ CASE_BIT, 8'h00, 8'h00};
    send_packet(assemble_packet(5, PROTO_TCP, 5, 16'd47, 16'd0, body));
    // A UDP length below its own header leaves no window despite the keyword in the payload.
    body = '{CH_U, CH_N, CH_I, CH_O, CH_N, 8'h00, 8'h00, 8'h00, 8'h00};
    send_packet(assemble_packet(5, PROTO_UDP, 5, 16'd37, 16'd7, body));
    drain();

    // Random phases. Each starts from an idle scanner, so the sender has waited for every
    // verdict before it; the limit moves through both extremes, small windows and the reset
    // value. One phase runs with no idling at all on either side.
    phase = 0;
    while (bytes_sent < 1900) begin
      case (phase)
        0:       limit = 16'd0;
        1:       limit = 16'hFFFF;
        2:       limit = 16'd11;
        3:       limit = 16'd7;
        4:       limit = SCAN_LIMIT_RESET;
        5:       limit = 16'd30;
        default: limit = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(40));
      endcase
      set_scan_limit(limit);
      jitter = (phase != 3);
      repeat (8) begin
        pkt = random_packet(limit, ($urandom_range(9) == 0) ? 60 : 24);
        bytes_sent += pkt.size();
        send_packet(pkt);
      end
      drain();
      phase++;
    end
    jitter = 1'b1;

    if (mismatches == 0) begin
      $display("PASS ipv4_payload_injection_scan");
    end else begin
      $display("FAIL ipv4_payload_injection_scan");
    end
    $finish;
  end

endmodule
